FILE: rtl/rhtr_pkg.sv
// ----------------------------------------------------------------------------
// rhtr_pkg
// shared types and codes of the reference count hash tracker
// ----------------------------------------------------------------------------
`default_nettype none

package rhtr_pkg;

   localparam logic [2:0] ACT_ADD    = 3'd0;
   localparam logic [2:0] ACT_REMOVE = 3'd1;
   localparam logic [2:0] ACT_STEAL  = 3'd2;
   localparam logic [2:0] ACT_FORGET = 3'd3;
   localparam logic [2:0] ACT_REPORT = 3'd4;

   localparam logic [31:0] KEY_EMPTY  = 32'd0;
   localparam logic [31:0] KEY_TOMB   = 32'd1;
   localparam logic [31:0] HASH_MULT  = 32'd2654435761;
   localparam int          HASH_SHIFT = 13;
   localparam int          HASH_BITS  = 32 - HASH_SHIFT;
   localparam int          QUEUE_DEPTH = 4;
   localparam int          QPTR_BITS   = 2;
   localparam logic [12:0] SAT13       = 13'd8191;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_IGNORED   = 3'd1,
      STATUS_FULL      = 3'd2,
      STATUS_STEAL_ERR = 3'd3,
      STATUS_FROZEN    = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      BS_CLEAR,
      BS_IDLE,
      BS_DISPATCH,
      BS_READ,
      BS_CHECK,
      BS_SCAN,
      BS_FINISH
   } back_state_type;

   typedef struct packed {
      logic [2:0]           action;
      logic [31:0]          key;
      logic [31:0]          caller;
      logic                 held_nz;
      logic [31:0]          since;
      logic [HASH_BITS-1:0] home;
      logic                 reserved;
   } req_entry_type;

endpackage

`default_nettype wire

FILE: rtl/rhtr_front.sv
// ----------------------------------------------------------------------------
// rhtr_front
// accepts items, hashes and classifies them, and queues them for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module rhtr_front
   import rhtr_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [2:0]    req_action,
   input  wire logic [31:0]   req_cluster_address,
   input  wire logic [31:0]   req_caller_tag,
   input  wire logic [31:0]   req_held_count,
   input  wire logic [31:0]   req_since_epoch,
   output req_entry_type      head,
   output logic               head_valid,
   input  wire logic          pop
);

   req_entry_type           queue_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]      fill_ff, fill_in;
   logic                    push;
   logic [31:0]             product;
   req_entry_type           entry;

   assign req_stall  = (fill_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign push       = req_valid && !req_stall;
   assign head       = queue_ff[rd_ptr_ff];
   assign head_valid = (fill_ff != '0);

   // home slot hash
   assign product = {4'b0000, req_cluster_address[31:4]} * HASH_MULT;

   always_comb begin
      entry          = '0;
      entry.action   = req_action;
      entry.key      = req_cluster_address;
      entry.caller   = req_caller_tag;
      entry.held_nz  = (req_held_count != 32'd0);
      entry.since    = req_since_epoch;
      entry.home     = product[31:HASH_SHIFT];
      entry.reserved = (req_cluster_address == KEY_EMPTY) ||
                       (req_cluster_address == KEY_TOMB);
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/rhtr_back.sv
// ----------------------------------------------------------------------------
// rhtr_back
// slot table, probe sequencer, report scan and result register
// ----------------------------------------------------------------------------
`default_nettype none

module rhtr_back
   import rhtr_pkg::*;
#(
   parameter int TABLE_SLOTS = 4096,
   parameter int COUNT_BITS  = 16
)
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire req_entry_type head,
   input  wire logic          head_valid,
   output logic               pop,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic [2:0]         rsp_status,
   output logic [31:0]        rsp_first_caller,
   output logic [12:0]        rsp_live_total,
   output logic [31:0]        rsp_epoch_now,
   output logic [12:0]        rsp_report_entries,
   output logic [31:0]        rsp_report_reasons
);

   localparam int SB = $clog2(TABLE_SLOTS);

   typedef struct packed {
      logic [31:0]           key;
      logic [31:0]           caller;
      logic [COUNT_BITS-1:0] count;
      logic [31:0]           epoch;
   } slot_type;

   slot_type        slot_mem_ff [TABLE_SLOTS];
   slot_type        rd_data_ff;

   back_state_type  state_ff, state_in;
   req_entry_type   cur_ff, cur_in;
   logic [SB-1:0]   probe_ff, probe_in;
   logic [SB:0]     steps_ff, steps_in;
   logic            have_tomb_ff, have_tomb_in;
   logic [SB-1:0]   tomb_ff, tomb_in;
   logic [SB:0]     scan_ff, scan_in;
   logic            scan_vld_ff, scan_vld_in;
   logic [12:0]     rep_n_ff, rep_n_in;
   logic [31:0]     rep_sum_ff, rep_sum_in;
   status_type      status_ff, status_in;
   logic [31:0]     first_ff, first_in;
   logic [SB:0]     live_ff, live_in;
   logic [31:0]     epoch_ff, epoch_in;
   logic            frozen_ff, frozen_in;
   logic [SB:0]     clr_ff, clr_in;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [2:0]      rsp_status_ff;
   logic [31:0]     rsp_first_ff;
   logic [12:0]     rsp_live_ff;
   logic [31:0]     rsp_epoch_ff;
   logic [12:0]     rsp_rep_n_ff;
   logic [31:0]     rsp_rep_sum_ff;
   logic            rsp_load;

   logic            mem_we;
   logic [SB-1:0]   mem_wa;
   slot_type        mem_wd;
   logic [SB-1:0]   mem_ra;

   // probe step classification
   logic            hit, empty, tomb, last_step, dispatch_probe;
   logic            is_add, is_remove, is_steal_err;
   logic            scan_done, scan_issue;
   logic [SB-1:0]   ins_dest;
   logic            ins_ok, add_stop, look_miss;
   slot_type        add_base, add_new, drop_new;
   logic            live_gone, going_live;
   logic            rep_take;
   logic [32:0]     rep_sum_wide;
   logic [31:0]     live_wide;

   assign hit       = (rd_data_ff.key == cur_ff.key);
   assign empty     = (rd_data_ff.key == KEY_EMPTY);
   assign tomb      = (rd_data_ff.key == KEY_TOMB);
   assign last_step = (steps_ff == (SB+1)'(TABLE_SLOTS - 1));
   assign is_add       = (cur_ff.action == ACT_ADD);
   assign is_remove    = (cur_ff.action == ACT_REMOVE);
   assign is_steal_err = (cur_ff.action == ACT_STEAL) && cur_ff.held_nz;

   assign dispatch_probe = !frozen_ff && !cur_ff.reserved &&
                           (cur_ff.action == ACT_ADD || cur_ff.action == ACT_REMOVE ||
                            cur_ff.action == ACT_STEAL || cur_ff.action == ACT_FORGET);

   // add: destination of a fresh entry
   always_comb begin
      ins_dest = have_tomb_ff ? tomb_ff : probe_ff;
      ins_ok   = 1'b0;
      add_stop = 1'b0;
      if (hit) begin
         add_stop = 1'b1;
      end else if (empty) begin
         add_stop = 1'b1;
         ins_ok   = 1'b1;
      end else if (last_step) begin
         add_stop = 1'b1;
         if (have_tomb_ff) begin
            ins_ok = 1'b1;
         end else if (tomb) begin
            ins_ok   = 1'b1;
            ins_dest = probe_ff;
         end
      end
   end

   assign look_miss = !hit && (empty || last_step);

   always_comb begin
      add_base = hit ? rd_data_ff : slot_type'('0);
      if (!hit) begin
         add_base.key = cur_ff.key;
      end
      going_live = (add_base.count == '0);
      add_new    = add_base;
      if (going_live) begin
         add_new.caller = cur_ff.caller;
         add_new.epoch  = epoch_ff + 32'd1;
      end
      if (add_base.count != {COUNT_BITS{1'b1}}) begin
         add_new.count = add_base.count + 1'b1;
      end
   end

   always_comb begin
      drop_new       = rd_data_ff;
      drop_new.key   = KEY_TOMB;
      drop_new.count = '0;
      live_gone      = (rd_data_ff.count != '0) && (live_ff != '0);
   end

   assign scan_issue = (scan_ff != (SB+1)'(TABLE_SLOTS));
   assign scan_done  = !scan_issue && !scan_vld_ff;
   assign rep_take   = scan_vld_ff && !empty && !tomb && (rd_data_ff.count != '0) &&
                       (rd_data_ff.epoch > cur_ff.since);
   assign rep_sum_wide = {1'b0, rep_sum_ff} + (33)'(rd_data_ff.count);
   assign rsp_load     = (state_ff == BS_FINISH) && (!rsp_valid_ff || !rsp_stall);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BS_CLEAR: begin
            if (clr_ff == (SB+1)'(TABLE_SLOTS - 1)) begin
               state_in = BS_IDLE;
            end
         end
         BS_IDLE: begin
            if (head_valid) begin
               state_in = BS_DISPATCH;
            end
         end
         BS_DISPATCH: begin
            if (dispatch_probe) begin
               state_in = BS_READ;
            end else if (!frozen_ff && cur_ff.action == ACT_REPORT) begin
               state_in = BS_SCAN;
            end else begin
               state_in = BS_FINISH;
            end
         end
         BS_READ: begin
            state_in = BS_CHECK;
         end
         BS_CHECK: begin
            if (is_add ? add_stop : (hit || look_miss)) begin
               state_in = BS_FINISH;
            end else begin
               state_in = BS_READ;
            end
         end
         BS_SCAN: begin
            if (scan_done) begin
               state_in = BS_FINISH;
            end
         end
         BS_FINISH: begin
            if (rsp_load) begin
               state_in = BS_IDLE;
            end
         end
         default: state_in = BS_IDLE;
      endcase
   end

   // datapath controls
   always_comb begin
      pop          = 1'b0;
      cur_in       = cur_ff;
      probe_in     = probe_ff;
      steps_in     = steps_ff;
      have_tomb_in = have_tomb_ff;
      tomb_in      = tomb_ff;
      scan_in      = scan_ff;
      scan_vld_in  = 1'b0;
      rep_n_in     = rep_n_ff;
      rep_sum_in   = rep_sum_ff;
      status_in    = status_ff;
      first_in     = first_ff;
      live_in      = live_ff;
      epoch_in     = epoch_ff;
      frozen_in    = frozen_ff;
      clr_in       = clr_ff;
      mem_we       = 1'b0;
      mem_wa       = probe_ff;
      mem_wd       = rd_data_ff;
      mem_ra       = probe_ff;
      unique case (state_ff)
         BS_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff[SB-1:0];
            mem_wd = '0;
            clr_in = clr_ff + 1'b1;
         end
         BS_IDLE: begin
            if (head_valid) begin
               pop        = 1'b1;
               cur_in     = head;
               status_in  = STATUS_OK;
               first_in   = '0;
               rep_n_in   = '0;
               rep_sum_in = '0;
            end
         end
         BS_DISPATCH: begin
            probe_in     = cur_ff.home[SB-1:0];
            steps_in     = '0;
            have_tomb_in = 1'b0;
            scan_in      = '0;
            if (frozen_ff) begin
               status_in = STATUS_FROZEN;
            end else if (cur_ff.action == ACT_REPORT) begin
               status_in = STATUS_OK;
            end else if (dispatch_probe) begin
               status_in = STATUS_OK;
            end else if (cur_ff.action == ACT_STEAL && cur_ff.held_nz) begin
               status_in = STATUS_STEAL_ERR;
               frozen_in = 1'b1;
            end else begin
               status_in = STATUS_IGNORED;
            end
         end
         BS_READ: begin
            mem_ra = probe_ff;
         end
         BS_CHECK: begin
            if (is_add) begin
               if (add_stop) begin
                  if (hit || ins_ok) begin
                     mem_we = 1'b1;
                     mem_wa = hit ? probe_ff : ins_dest;
                     mem_wd = add_new;
                     if (going_live) begin
                        epoch_in = epoch_ff + 32'd1;
                        live_in  = live_ff + 1'b1;
                     end
                  end else begin
                     status_in = STATUS_FULL;
                  end
               end else if (tomb && !have_tomb_ff) begin
                  have_tomb_in = 1'b1;
                  tomb_in      = probe_ff;
               end
            end else if (is_steal_err) begin
               if (hit || look_miss) begin
                  status_in = STATUS_STEAL_ERR;
                  first_in  = hit ? rd_data_ff.caller : 32'd0;
                  frozen_in = 1'b1;
               end
            end else if (hit) begin
               mem_we = 1'b1;
               if (is_remove && rd_data_ff.count > COUNT_BITS'(1)) begin
                  mem_wd       = rd_data_ff;
                  mem_wd.count = rd_data_ff.count - 1'b1;
               end else begin
                  mem_wd = drop_new;
                  if (live_gone) begin
                     live_in = live_ff - 1'b1;
                  end
               end
            end else if (look_miss) begin
               status_in = STATUS_IGNORED;
            end
            probe_in = probe_ff + 1'b1;
            steps_in = steps_ff + 1'b1;
         end
         BS_SCAN: begin
            mem_ra      = scan_ff[SB-1:0];
            scan_vld_in = scan_issue;
            if (scan_issue) begin
               scan_in = scan_ff + 1'b1;
            end
            if (rep_take) begin
               if (rep_n_ff != SAT13) begin
                  rep_n_in = rep_n_ff + 13'd1;
               end
               rep_sum_in = rep_sum_wide[32] ? 32'hFFFF_FFFF : rep_sum_wide[31:0];
            end
         end
         BS_FINISH: begin
            pop = 1'b0;
         end
         default: pop = 1'b0;
      endcase
   end

   assign live_wide = 32'(live_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BS_CLEAR;
         clr_ff       <= '0;
         live_ff      <= '0;
         epoch_ff     <= '0;
         frozen_ff    <= 1'b0;
         scan_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         live_ff      <= live_in;
         epoch_ff     <= epoch_in;
         frozen_ff    <= frozen_in;
         scan_vld_ff  <= scan_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      probe_ff     <= probe_in;
      steps_ff     <= steps_in;
      have_tomb_ff <= have_tomb_in;
      tomb_ff      <= tomb_in;
      scan_ff      <= scan_in;
      rep_n_ff     <= rep_n_in;
      rep_sum_ff   <= rep_sum_in;
      status_ff    <= status_in;
      first_ff     <= first_in;
      if (rsp_load) begin
         rsp_status_ff  <= status_ff;
         rsp_first_ff   <= first_ff;
         rsp_live_ff    <= (live_wide > 32'(SAT13)) ? SAT13 : live_wide[12:0];
         rsp_epoch_ff   <= epoch_ff;
         rsp_rep_n_ff   <= rep_n_ff;
         rsp_rep_sum_ff <= rep_sum_ff;
      end
   end

   // slot memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem_ff[mem_wa] <= mem_wd;
      end
      rd_data_ff <= slot_mem_ff[mem_ra];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_first_caller   = rsp_first_ff;
   assign rsp_live_total     = rsp_live_ff;
   assign rsp_epoch_now      = rsp_epoch_ff;
   assign rsp_report_entries = rsp_rep_n_ff;
   assign rsp_report_reasons = rsp_rep_sum_ff;

endmodule

`default_nettype wire

FILE: rtl/refcount_hash_tracker_unit.sv
// ----------------------------------------------------------------------------
// refcount_hash_tracker_unit
// reference count tracker over a linear probing hash table with tombstones
// ----------------------------------------------------------------------------
// After reset the unit clears its slot memory, one slot a cycle, before it
// takes the first item off its queue; items are still accepted into a
// four-entry queue meanwhile. An add, remove, steal or forget reads and
// checks each slot on its probe path in turn, through the one read port of
// the slot memory, which is read once per probe step. A report scans every
// slot. Reserved keys, unknown actions and any item after a failed steal
// skip the table and go straight to the result.
`default_nettype none

module refcount_hash_tracker_unit
   import rhtr_pkg::*;
#(
   parameter int TABLE_SLOTS = 4096,
   parameter int COUNT_BITS  = 16
)
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [2:0]    req_action,
   input  wire logic [31:0]   req_cluster_address,
   input  wire logic [31:0]   req_caller_tag,
   input  wire logic [31:0]   req_held_count,
   input  wire logic [31:0]   req_since_epoch,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic [2:0]         rsp_status,
   output logic [31:0]        rsp_first_caller,
   output logic [12:0]        rsp_live_total,
   output logic [31:0]        rsp_epoch_now,
   output logic [12:0]        rsp_report_entries,
   output logic [31:0]        rsp_report_reasons
);

   req_entry_type head;
   logic          head_valid;
   logic          pop;

   rhtr_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_cluster_address (req_cluster_address),
      .req_caller_tag      (req_caller_tag),
      .req_held_count      (req_held_count),
      .req_since_epoch     (req_since_epoch),
      .head                (head),
      .head_valid          (head_valid),
      .pop                 (pop)
   );

   rhtr_back #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .head_valid         (head_valid),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_first_caller   (rsp_first_caller),
      .rsp_live_total     (rsp_live_total),
      .rsp_epoch_now      (rsp_epoch_now),
      .rsp_report_entries (rsp_report_entries),
      .rsp_report_reasons (rsp_report_reasons)
   );

endmodule

`default_nettype wire

FILE: dv/refcount_hash_tracker_unit_test.sv
// ----------------------------------------------------------------------------
// refcount_hash_tracker_unit_test
// self-checking bench for the reference count hash tracker
// ----------------------------------------------------------------------------
// A directed table covers reserved keys, untracked keys, tombstone reuse,
// unknown actions and reports. A short burst of adds runs with no idling.
// Random traffic over a small key pool follows, and the run ends with a
// failed steal and the frozen state. Each result is checked against the
// table's expected values for typed rows, else against a behavioral model.
`timescale 1ns / 100ps
`default_nettype none

module refcount_hash_tracker_unit_test;
   import rhtr_pkg::*;

   localparam int SLOTS     = 4096;
   localparam int COUNT_TOP = 65535;
   localparam int POOL_SIZE = 48;

   typedef struct {
      logic [2:0]  act;
      logic [31:0] addr;
      logic [31:0] caller;
      logic [31:0] held;
      logic [31:0] since;
   } req_item_type;

   typedef struct {
      status_type  status;
      logic [31:0] first;
      logic [12:0] live;
      logic [31:0] epoch;
      logic [12:0] rep_n;
      logic [31:0] rep_sum;
   } outcome_type;

   typedef struct {
      req_item_type item;
      bit           typed;
      outcome_type  want;
   } table_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_action = ACT_ADD;
   logic [31:0] req_cluster_address = '0;
   logic [31:0] req_caller_tag = '0;
   logic [31:0] req_held_count = '0;
   logic [31:0] req_since_epoch = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_first_caller;
   logic [12:0] rsp_live_total;
   logic [31:0] rsp_epoch_now;
   logic [12:0] rsp_report_entries;
   logic [31:0] rsp_report_reasons;

   refcount_hash_tracker_unit uut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // tracker model state
   bit [31:0] slot_key_m[SLOTS];
   bit [31:0] slot_caller_m[SLOTS];
   bit [31:0] slot_epoch_m[SLOTS];
   int        slot_count_m[SLOTS];
   int        live_m;
   bit [31:0] epoch_m;
   bit        frozen_m;

   outcome_type pending_results[$];
   bit          quiet = 1'b0;
   int          failures = 0;
   int          rsp_hold = 0;

   function automatic int home_of(bit [31:0] key);
      bit [31:0] h;
      h = (key >> 4) * HASH_MULT;
      return (h >> HASH_SHIFT) & (SLOTS - 1);
   endfunction

   function automatic bit is_reserved(bit [31:0] key);
      return key == KEY_EMPTY || key == KEY_TOMB;
   endfunction

   function automatic int find_slot(bit [31:0] key);
      int b;
      if (is_reserved(key)) return -1;
      b = home_of(key);
      for (int n = 0; n < SLOTS; n++) begin
         if (slot_key_m[b] == KEY_EMPTY) return -1;
         if (slot_key_m[b] == key) return b;
         b = (b + 1) & (SLOTS - 1);
      end
      return -1;
   endfunction

   function automatic int place_slot(bit [31:0] key);
      int b, n, tomb;
      b = home_of(key);
      tomb = -1;
      for (n = 0; n < SLOTS; n++) begin
         if (slot_key_m[b] == key) return b;
         if (slot_key_m[b] == KEY_EMPTY) break;
         if (slot_key_m[b] == KEY_TOMB && tomb < 0) tomb = b;
         b = (b + 1) & (SLOTS - 1);
      end
      if (tomb >= 0) b = tomb;
      else if (n >= SLOTS) return -1;
      slot_key_m[b] = key;
      slot_caller_m[b] = '0;
      slot_count_m[b] = 0;
      slot_epoch_m[b] = '0;
      return b;
   endfunction

   function automatic void drop_entry(int i);
      if (slot_count_m[i] > 0 && live_m > 0) live_m--;
      slot_count_m[i] = 0;
      slot_key_m[i] = KEY_TOMB;
   endfunction

   function automatic outcome_type track_step(req_item_type it);
      outcome_type o;
      int s;
      longint sum;
      o = '{STATUS_OK, '0, '0, '0, '0, '0};
      sum = 0;
      if (frozen_m) begin
         o.status = STATUS_FROZEN;
      end else if (it.act == ACT_ADD) begin
         if (is_reserved(it.addr)) begin
            o.status = STATUS_IGNORED;
         end else begin
            s = place_slot(it.addr);
            if (s < 0) begin
               o.status = STATUS_FULL;
            end else begin
               if (slot_count_m[s] == 0) begin
                  slot_caller_m[s] = it.caller;
                  epoch_m++;
                  slot_epoch_m[s] = epoch_m;
                  live_m++;
               end
               if (slot_count_m[s] < COUNT_TOP) slot_count_m[s]++;
            end
         end
      end else if (it.act == ACT_REMOVE) begin
         s = find_slot(it.addr);
         if (s < 0) o.status = STATUS_IGNORED;
         else if (slot_count_m[s] <= 1) drop_entry(s);
         else slot_count_m[s]--;
      end else if (it.act == ACT_STEAL && it.held != 0) begin
         s = find_slot(it.addr);
         o.first = (s >= 0) ? slot_caller_m[s] : '0;
         o.status = STATUS_STEAL_ERR;
         frozen_m = 1'b1;
      end else if (it.act == ACT_STEAL || it.act == ACT_FORGET) begin
         s = find_slot(it.addr);
         if (s < 0) o.status = STATUS_IGNORED;
         else drop_entry(s);
      end else if (it.act == ACT_REPORT) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (is_reserved(slot_key_m[i]) || slot_count_m[i] == 0) continue;
            if (slot_epoch_m[i] <= it.since) continue;
            if (o.rep_n < SAT13) o.rep_n++;
            sum += slot_count_m[i];
         end
         o.rep_sum = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
      end else begin
         o.status = STATUS_IGNORED;
      end
      o.live = (live_m > SAT13) ? SAT13 : live_m[12:0];
      o.epoch = epoch_m;
      return o;
   endfunction

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send(req_item_type it, bit typed, outcome_type want);
      int gap;
      outcome_type got;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= it.act;
      req_cluster_address <= it.addr;
      req_caller_tag <= it.caller;
      req_held_count <= it.held;
      req_since_epoch <= it.since;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      got = track_step(it);
      pending_results.push_back(typed ? want : got);
   endtask

   task automatic send_plain(req_item_type it);
      send(it, 1'b0, '{STATUS_OK, '0, '0, '0, '0, '0});
   endtask

   task automatic report_mismatch(string field, logic [31:0] e, logic [31:0] a);
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, e, a);
      failures++;
   endtask

   always @(posedge clock) begin
      outcome_type e;
      if (rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected item, status %h", $time, rsp_status);
            failures++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_status !== e.status) report_mismatch("status", e.status, rsp_status);
            if (rsp_first_caller !== e.first)
               report_mismatch("first_caller", e.first, rsp_first_caller);
            if (rsp_live_total !== e.live)
               report_mismatch("live_total", e.live, rsp_live_total);
            if (rsp_epoch_now !== e.epoch)
               report_mismatch("epoch_now", e.epoch, rsp_epoch_now);
            if (rsp_report_entries !== e.rep_n)
               report_mismatch("report_entries", e.rep_n, rsp_report_entries);
            if (rsp_report_reasons !== e.rep_sum)
               report_mismatch("report_reasons", e.rep_sum, rsp_report_reasons);
         end
      end
      if (quiet) begin
         rsp_hold = 0;
         rsp_stall <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_hold = ($urandom_range(0, 99) < 5) ? $urandom_range(10, 40) :
                    ($urandom_range(0, 99) < 30) ? $urandom_range(1, 3) : 0;
         rsp_stall <= (rsp_hold > 0);
      end
   end

   initial begin
      #100ms;
      $display("Verification failed");
      $finish;
   end

   initial begin
      table_row_type directed[$];
      bit [31:0]     pool[POOL_SIZE];
      req_item_type  it;
      int            r;

      for (int i = 0; i < SLOTS; i++) begin
         slot_key_m[i] = '0;
         slot_caller_m[i] = '0;
         slot_epoch_m[i] = '0;
         slot_count_m[i] = 0;
      end
      live_m = 0;
      epoch_m = '0;
      frozen_m = 1'b0;

      directed = '{
         '{'{ACT_REPORT, 32'h0, 32'h0, 32'h0, 32'h0}, 1,
           '{STATUS_OK, 32'h0, 13'd0, 32'd0, 13'd0, 32'd0}},
         '{'{ACT_ADD, 32'h0, 32'h1234, 32'h0, 32'h0}, 1,
           '{STATUS_IGNORED, 32'h0, 13'd0, 32'd0, 13'd0, 32'd0}},
         '{'{ACT_ADD, 32'h1, 32'h0, 32'h0, 32'h0}, 1,
           '{STATUS_IGNORED, 32'h0, 13'd0, 32'd0, 13'd0, 32'd0}},
         '{'{ACT_REMOVE, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0}, 1,
           '{STATUS_IGNORED, 32'h0, 13'd0, 32'd0, 13'd0, 32'd0}},
         '{'{ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1,
           '{STATUS_OK, 32'h0, 13'd1, 32'd1, 13'd0, 32'd0}},
         '{'{ACT_ADD, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0}, 1,
           '{STATUS_OK, 32'h0, 13'd1, 32'd1, 13'd0, 32'd0}},
         '{'{ACT_ADD, 32'h10, 32'h0, 32'h0, 32'h0}, 1,
           '{STATUS_OK, 32'h0, 13'd2, 32'd2, 13'd0, 32'd0}},
         '{'{ACT_REPORT, 32'h0, 32'h0, 32'h0, 32'h0}, 1,
           '{STATUS_OK, 32'h0, 13'd2, 32'd2, 13'd2, 32'd3}},
         '{'{ACT_REPORT, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF}, 1,
           '{STATUS_OK, 32'h0, 13'd2, 32'd2, 13'd0, 32'd0}},
         '{'{ACT_REPORT, 32'h0, 32'h0, 32'h0, 32'h1}, 0, '{STATUS_OK, 0, 0, 0, 0, 0}},
         '{'{ACT_REMOVE, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0}, 0, '{STATUS_OK, 0, 0, 0, 0, 0}},
         '{'{ACT_REMOVE, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0}, 1,
           '{STATUS_OK, 32'h0, 13'd1, 32'd2, 13'd0, 32'd0}},
         '{'{ACT_ADD, 32'hFFFF_FFFF, 32'h5, 32'h0, 32'h0}, 0, '{STATUS_OK, 0, 0, 0, 0, 0}},
         '{'{ACT_FORGET, 32'h10, 32'h0, 32'h0, 32'h0}, 0, '{STATUS_OK, 0, 0, 0, 0, 0}},
         '{'{ACT_FORGET, 32'h10, 32'h0, 32'h0, 32'h0}, 0, '{STATUS_OK, 0, 0, 0, 0, 0}},
         '{'{ACT_STEAL, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0}, 0, '{STATUS_OK, 0, 0, 0, 0, 0}},
         '{'{ACT_STEAL, 32'h1234_5678, 32'h0, 32'h0, 32'h0}, 0, '{STATUS_OK, 0, 0, 0, 0, 0}},
         '{'{ACT_STEAL, 32'h0, 32'h0, 32'h0, 32'h0}, 0, '{STATUS_OK, 0, 0, 0, 0, 0}},
         '{'{ACT_REMOVE, 32'h1, 32'h0, 32'h0, 32'h0}, 0, '{STATUS_OK, 0, 0, 0, 0, 0}},
         '{'{ACT_FORGET, 32'h0, 32'h0, 32'h0, 32'h0}, 0, '{STATUS_OK, 0, 0, 0, 0, 0}},
         '{'{3'd5, 32'hABCD_0000, 32'h0, 32'h0, 32'h0}, 1,
           '{STATUS_IGNORED, 32'h0, 13'd0, 32'd3, 13'd0, 32'd0}},
         '{'{3'd6, 32'h0, 32'h0, 32'h0, 32'h0}, 0, '{STATUS_OK, 0, 0, 0, 0, 0}},
         '{'{3'd7, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0}, 0, '{STATUS_OK, 0, 0, 0, 0, 0}}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send(directed[i].item, directed[i].typed, directed[i].want);

      // back to back adds, no idling on either side
      quiet = 1'b1;
      it = '{ACT_ADD, 32'h00AB_CDE0, 32'hC0FF_EE00, 32'h0, 32'h0};
      repeat (6) send_plain(it);
      send_plain('{ACT_REPORT, 32'h0, 32'h0, 32'h0, 32'h0});
      send_plain('{ACT_REMOVE, 32'h00AB_CDE0, 32'h0, 32'h0, 32'h0});
      send_plain('{ACT_FORGET, 32'h00AB_CDE0, 32'h0, 32'h0, 32'h0});
      quiet = 1'b0;

      foreach (pool[i]) pool[i] = $urandom() | 32'h2;
      for (int n = 0; n < 1400; n++) begin
         if (n % 300 == 250) quiet = 1'b1;
         if (n % 300 == 290) quiet = 1'b0;
         it.addr = pool[$urandom_range(0, POOL_SIZE - 1)];
         r = $urandom_range(0, 99);
         if (r < 3) it.addr = $urandom_range(0, 1);
         else if (r < 8) it.addr = $urandom();
         it.caller = $urandom();
         it.held = $urandom();
         it.since = $urandom();
         r = $urandom_range(0, 99);
         if (r < 42) it.act = ACT_ADD;
         else if (r < 67) it.act = ACT_REMOVE;
         else if (r < 78) it.act = ACT_FORGET;
         else if (r < 92) begin
            it.act = ACT_STEAL;
            it.held = '0;
         end else if (r < 94) begin
            it.act = ACT_REPORT;
            it.since = ($urandom_range(0, 1) != 0) ? $urandom_range(0, epoch_m) : $urandom();
         end else it.act = 3'($urandom_range(5, 7));
         send_plain(it);
      end

      send_plain('{ACT_ADD, 32'hDEAD_BEE0, 32'h0, 32'h0, 32'h0});
      send_plain('{ACT_REPORT, 32'h0, 32'h0, 32'h0, 32'h0});
      send_plain('{ACT_STEAL, 32'h0001_0010, 32'h0, 32'h8000_0000, 32'h0});
      send_plain('{ACT_ADD, 32'h0000_1230, 32'h0, 32'h0, 32'h0});
      send_plain('{ACT_REPORT, 32'h0, 32'h0, 32'h0, 32'h0});
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
